@@ hdl/buddy_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");
// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");
`else
`define BBA_ASSERT_NOW(label, ante, cons)
`define BBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, types and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int MAX_ORDERS = 11;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = BLK_W + 1;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = BLK_W + 1;
    localparam int WIDE_W     = BLK_W + 2;
    localparam int STEP_W     = BLK_W + 2;
    localparam int STEP_CAP   = 2 * MAX_BLOCKS;
    localparam int OI_W       = $clog2(MAX_ORDERS);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_code_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_INIT_LOOP, S_A_CHK, S_A_POP, S_A_SCAN, S_A_TAKE,
        S_A_SPLIT, S_F_CHK, S_F_START, S_F_WALK, S_F_NEXT, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_CAPTURE, CMD_INIT_START, CMD_INIT_CHUNK, CMD_A_POP_RD,
        CMD_A_POP, CMD_A_SCAN_INIT, CMD_A_SCAN_NEXT, CMD_A_TAKE_RD, CMD_A_TAKE,
        CMD_A_SPLIT, CMD_A_FINAL, CMD_F_START, CMD_F_PUSH, CMD_F_PROBE,
        CMD_F_NEXT, CMD_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_p;
        logic   res_fail;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_init;
        logic rem_zero;
        logic order_ok;
        logic head_nz;
        logic scan_end;
        logic scan_hit;
        logic split_more;
        logic free_ok;
        logic walk_end;
        logic hit;
    } dp_stat_t;

    // index of the highest set bit
    function automatic logic [ORD_W-1:0] msb_pos(input logic [BLK_W-1:0] v);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLK_W; i++) begin
            if (v[i]) begin
                r = ORD_W'(i);
            end
        end
        return r;
    endfunction

    // chunk at block b of order k lines up with the pool end
    function automatic logic end_aligned(input logic [LINK_W-1:0] b,
                                         input logic [ORD_W-1:0] k,
                                         input logic [CNT_W-1:0] pt);
        logic [WIDE_W-1:0] mask;
        logic [WIDE_W-1:0] num;
        mask = (WIDE_W'(1) << k) - WIDE_W'(1);
        num  = ((WIDE_W'(pt) - WIDE_W'(1)) & mask) + WIDE_W'(1);
        return (WIDE_W'(b) & mask) == (num & mask);
    endfunction

endpackage

@@ hdl/bba_req_if.sv @@
// ----------------------------------------------------------------------------
// bba_req_if
// request channel: op, order and block index
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [3:0]                  order;
    logic [bba_pkg::BLK_W-1:0]   block_index;

    modport source (output valid, output op, output order, output block_index,
                    input ready);
    modport sink   (input valid, input op, input order, input block_index,
                    output ready);
endinterface

@@ hdl/bba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bba_rsp_if
// response channel: allocated block and status
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::BLK_W-1:0]   block_index_out;
    logic                        status;

    modport source (output valid, output block_index_out, output status,
                    input ready);
    modport sink   (input valid, input block_index_out, input status,
                    output ready);
endinterface

@@ hdl/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// block-granular buddy allocator with one free list per power-of-two order
// ----------------------------------------------------------------------------
// Takes one request word at a time (alloc, free or init) and returns exactly
// one response word per request. Requests are taken only while the sequencer
// is idle; a finished response sits in an output register so the next request
// can be accepted before the response is taken. Init writes one initial
// chunk per step, at most 10 chunks; alloc pops the list head on a hit,
// otherwise scans the orders above and splits one level per step; free
// probes each node of its order's list for a buddy and merges upward one
// level per hit. List pops and walk steps wait on the registered read of
// the link ram. Block 0 is reserved and doubles as the null link. The pool
// size register is sampled by init only and must be written while idle. The
// link ram has no reset; every entry is written before it is read. Links of
// blocks past the ram read as empty.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    bba_req_if.sink                   req,
    bba_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] cfg_wdata
);
    // command and status between sequencer and datapath
    bba_pkg::dp_cmd_t  cmd;
    bba_pkg::dp_stat_t st;

    // sequencer: owns the request ready and response valid
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: list heads, link ram, pool size and response word
    bba_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .req_order           (req.order),
        .req_block_index     (req.block_index),
        .cmd                 (cmd),
        .st                  (st),
        .rsp_block_index_out (rsp.block_index_out),
        .rsp_status          (rsp.status)
    );

    // one request in flight at a time
    `BBA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    // a failed response never carries a block
    `BBA_ASSERT_NOW(a_fail_no_block, rsp.valid && rsp.status, rsp.block_index_out == '0)
endmodule

@@ hdl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hdl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer for init, alloc and free, plus response valid
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_op,
    output logic               req_ready,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    input  bba_pkg::dp_stat_t  st,
    output bba_pkg::dp_cmd_t   cmd
);
    bba_pkg::state_t state_reg, state_next;
    logic fail_reg, fail_next;
    logic usep_reg, usep_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic out_free;
    bba_pkg::op_code_t op_code;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign op_code  = bba_pkg::op_code_t'(req_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_IDLE;
            fail_reg      <= 1'b0;
            usep_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fail_reg      <= fail_next;
            usep_reg      <= usep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        fail_next  = fail_reg;
        usep_next  = usep_reg;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (op_code)
                        bba_pkg::OP_ALLOC: state_next = bba_pkg::S_A_CHK;
                        bba_pkg::OP_FREE:  state_next = bba_pkg::S_F_CHK;
                        bba_pkg::OP_INIT:  state_next = bba_pkg::S_INIT;
                        default:
                        begin
                            state_next = bba_pkg::S_DONE;
                            fail_next  = 1'b1;
                            usep_next  = 1'b0;
                        end
                    endcase
                end
            end
            bba_pkg::S_INIT:
            begin
                if (st.bad_init)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b1;
                    usep_next  = 1'b0;
                end
                else
                begin
                    state_next = bba_pkg::S_INIT_LOOP;
                end
            end
            bba_pkg::S_INIT_LOOP:
            begin
                if (st.rem_zero)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b0;
                    usep_next  = 1'b0;
                end
            end
            bba_pkg::S_A_CHK:
            begin
                if (!st.order_ok)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b1;
                    usep_next  = 1'b0;
                end
                else if (st.head_nz)
                begin
                    state_next = bba_pkg::S_A_POP;
                end
                else
                begin
                    state_next = bba_pkg::S_A_SCAN;
                end
            end
            bba_pkg::S_A_POP:
            begin
                state_next = bba_pkg::S_DONE;
                fail_next  = 1'b0;
                usep_next  = 1'b1;
            end
            bba_pkg::S_A_SCAN:
            begin
                if (st.scan_end)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b1;
                    usep_next  = 1'b0;
                end
                else if (st.scan_hit)
                begin
                    state_next = bba_pkg::S_A_TAKE;
                end
            end
            bba_pkg::S_A_TAKE:
            begin
                state_next = bba_pkg::S_A_SPLIT;
            end
            bba_pkg::S_A_SPLIT:
            begin
                if (!st.split_more)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b0;
                    usep_next  = 1'b1;
                end
            end
            bba_pkg::S_F_CHK:
            begin
                if (st.free_ok)
                begin
                    state_next = bba_pkg::S_F_START;
                end
                else
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b1;
                    usep_next  = 1'b0;
                end
            end
            bba_pkg::S_F_START:
            begin
                if (st.order_ok)
                begin
                    state_next = bba_pkg::S_F_WALK;
                end
                else
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b0;
                    usep_next  = 1'b0;
                end
            end
            bba_pkg::S_F_WALK:
            begin
                if (st.walk_end)
                begin
                    state_next = bba_pkg::S_DONE;
                    fail_next  = 1'b0;
                    usep_next  = 1'b0;
                end
                else
                begin
                    state_next = bba_pkg::S_F_NEXT;
                end
            end
            bba_pkg::S_F_NEXT:
            begin
                state_next = st.hit ? bba_pkg::S_F_START : bba_pkg::S_F_WALK;
            end
            bba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default: state_next = bba_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = bba_pkg::CMD_IDLE;
        cmd.res_p      = usep_reg;
        cmd.res_fail   = fail_reg;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = bba_pkg::CMD_CAPTURE;
                end
            end
            bba_pkg::S_INIT:
            begin
                if (!st.bad_init)
                begin
                    cmd.op = bba_pkg::CMD_INIT_START;
                end
            end
            bba_pkg::S_INIT_LOOP:
            begin
                if (!st.rem_zero)
                begin
                    cmd.op = bba_pkg::CMD_INIT_CHUNK;
                end
            end
            bba_pkg::S_A_CHK:
            begin
                if (st.order_ok)
                begin
                    cmd.op = st.head_nz ? bba_pkg::CMD_A_POP_RD : bba_pkg::CMD_A_SCAN_INIT;
                end
            end
            bba_pkg::S_A_POP:   cmd.op = bba_pkg::CMD_A_POP;
            bba_pkg::S_A_SCAN:
            begin
                if (!st.scan_end)
                begin
                    cmd.op = st.scan_hit ? bba_pkg::CMD_A_TAKE_RD : bba_pkg::CMD_A_SCAN_NEXT;
                end
            end
            bba_pkg::S_A_TAKE:  cmd.op = bba_pkg::CMD_A_TAKE;
            bba_pkg::S_A_SPLIT:
            begin
                cmd.op = st.split_more ? bba_pkg::CMD_A_SPLIT : bba_pkg::CMD_A_FINAL;
            end
            bba_pkg::S_F_CHK:   cmd.op = bba_pkg::CMD_IDLE;
            bba_pkg::S_F_START:
            begin
                if (st.order_ok)
                begin
                    cmd.op = bba_pkg::CMD_F_START;
                end
            end
            bba_pkg::S_F_WALK:
            begin
                cmd.op = st.walk_end ? bba_pkg::CMD_F_PUSH : bba_pkg::CMD_F_PROBE;
            end
            bba_pkg::S_F_NEXT:  cmd.op = bba_pkg::CMD_F_NEXT;
            bba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op         = bba_pkg::CMD_LOAD_OUT;
                    rsp_valid_next = 1'b1;
                end
            end
            default: cmd.op = bba_pkg::CMD_IDLE;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

@@ hdl/bba_dp.sv @@
// ----------------------------------------------------------------------------
// bba_dp
// list heads, link ram, walk registers and response payload
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
    input  logic [3:0]                req_order,
    input  logic [bba_pkg::BLK_W-1:0] req_block_index,
    input  bba_pkg::dp_cmd_t          cmd,
    output bba_pkg::dp_stat_t         st,
    output logic [bba_pkg::BLK_W-1:0] rsp_block_index_out,
    output logic                      rsp_status
);
    localparam int BW = bba_pkg::BLK_W;
    localparam int LW = bba_pkg::LINK_W;
    localparam int OW = bba_pkg::ORD_W;
    localparam int CW = bba_pkg::CNT_W;
    localparam int WW = bba_pkg::WIDE_W;
    localparam int SW = bba_pkg::STEP_W;
    localparam int IW = bba_pkg::OI_W;

    logic [LW-1:0] heads_reg [bba_pkg::MAX_ORDERS];
    logic [CW-1:0] total_reg, pool_reg;
    logic [OW-1:0] oc_reg, n_reg, i_reg, j_reg;
    logic [BW-1:0] rem_reg;
    logic [LW-1:0] x_reg, p_reg, cur_reg, prev_reg, base_reg;
    logic [SW-1:0] steps_reg;
    logic          hit_reg;
    logic [BW-1:0] out_block_reg;
    logic          out_status_reg;
    logic          link_hi_reg;

    logic          ram_we;
    logic [BW-1:0] ram_waddr, ram_raddr;
    logic [LW-1:0] ram_wdata, ram_rdata;
    logic          link_we;
    logic [LW-1:0] link_wa, link_ra, link_q;

    logic [BW-1:0] rem0, chunk_pw, chunk_start;
    logic [LW-1:0] head_n, head_i, split_q;
    logic [OW-1:0] chunk_k, init_oc, kk;
    logic [WW-1:0] len, x_len, cur_len;
    logic          hit_r, hit_l;

    bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::MAX_BLOCKS)) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // guarded head reads
    assign head_n = (n_reg < OW'(bba_pkg::MAX_ORDERS)) ? heads_reg[n_reg[IW-1:0]] : '0;
    assign head_i = (i_reg < OW'(bba_pkg::MAX_ORDERS)) ? heads_reg[i_reg[IW-1:0]] : '0;

    // init helpers
    assign rem0        = BW'(total_reg - CW'(1));
    assign init_oc     = bba_pkg::msb_pos(rem0) + OW'(1);
    assign chunk_k     = bba_pkg::msb_pos(rem_reg);
    assign chunk_pw    = BW'(1) << chunk_k;
    assign chunk_start = rem_reg - chunk_pw + BW'(1);

    // split target, may land past the ram
    assign split_q = p_reg + (LW'(1) << (j_reg - OW'(1)));

    // buddy probe
    assign kk      = n_reg + OW'(1);
    assign len     = WW'(1) << n_reg;
    assign x_len   = WW'(x_reg) + len;
    assign cur_len = WW'(cur_reg) + len;
    assign hit_r   = (WW'(cur_reg) == x_len) && bba_pkg::end_aligned(x_reg, kk, pool_reg);
    assign hit_l   = (WW'(cur_reg) != x_len) && (WW'(x_reg) == cur_len)
                     && bba_pkg::end_aligned(cur_reg, kk, pool_reg);

    always_comb
    begin
        st.bad_init   = (total_reg < CW'(2)) || (total_reg > CW'(bba_pkg::MAX_BLOCKS));
        st.rem_zero   = (rem_reg == '0);
        st.order_ok   = (n_reg < oc_reg);
        st.head_nz    = (head_n != '0);
        st.scan_end   = (i_reg >= oc_reg);
        st.scan_hit   = (head_i != '0);
        st.split_more = (j_reg > n_reg);
        st.free_ok    = (n_reg < oc_reg) && (x_reg != '0) && (CW'(x_reg) < pool_reg);
        st.walk_end   = (cur_reg == '0) || (steps_reg >= SW'(bba_pkg::STEP_CAP));
        st.hit        = hit_reg;
    end

    // link accesses
    always_comb
    begin
        link_we   = 1'b0;
        link_wa   = '0;
        ram_wdata = '0;
        link_ra   = '0;
        case (cmd.op)
            bba_pkg::CMD_INIT_CHUNK:
            begin
                link_we = 1'b1;
                link_wa = LW'(chunk_start);
            end
            bba_pkg::CMD_A_POP_RD:  link_ra = head_n;
            bba_pkg::CMD_A_TAKE_RD: link_ra = head_i;
            bba_pkg::CMD_A_SPLIT:
            begin
                link_we = 1'b1;
                link_wa = split_q;
            end
            bba_pkg::CMD_A_POP, bba_pkg::CMD_A_FINAL:
            begin
                link_we = 1'b1;
                link_wa = p_reg;
            end
            bba_pkg::CMD_F_PUSH:
            begin
                link_we   = 1'b1;
                link_wa   = x_reg;
                ram_wdata = head_n;
            end
            bba_pkg::CMD_F_PROBE:   link_ra = cur_reg;
            bba_pkg::CMD_F_NEXT:
            begin
                link_we   = hit_reg && (prev_reg != '0);
                link_wa   = prev_reg;
                ram_wdata = link_q;
            end
            default: link_we = 1'b0;
        endcase
    end

    // links of blocks past the ram drop writes and read as empty
    assign ram_we    = link_we && (link_wa < LW'(bba_pkg::MAX_BLOCKS));
    assign ram_waddr = link_wa[BW-1:0];
    assign ram_raddr = link_ra[BW-1:0];
    assign link_q    = link_hi_reg ? '0 : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_hi_reg <= 1'b0;
        end
        else
        begin
            link_hi_reg <= (link_ra >= LW'(bba_pkg::MAX_BLOCKS));
        end
    end

    // control state: pool setup and free lists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CW'(bba_pkg::MAX_BLOCKS);
            pool_reg  <= '0;
            oc_reg    <= '0;
            for (int k = 0; k < bba_pkg::MAX_ORDERS; k++)
            begin
                heads_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            case (cmd.op)
                bba_pkg::CMD_INIT_START:
                begin
                    pool_reg <= total_reg;
                    oc_reg   <= init_oc;
                    for (int k = 0; k < bba_pkg::MAX_ORDERS; k++)
                    begin
                        heads_reg[k] <= '0;
                    end
                end
                bba_pkg::CMD_INIT_CHUNK: heads_reg[chunk_k[IW-1:0]] <= LW'(chunk_start);
                bba_pkg::CMD_A_POP:      heads_reg[n_reg[IW-1:0]] <= link_q;
                bba_pkg::CMD_A_TAKE:     heads_reg[i_reg[IW-1:0]] <= link_q;
                bba_pkg::CMD_A_SPLIT:
                begin
                    heads_reg[IW'(j_reg - OW'(1))] <= split_q;
                end
                bba_pkg::CMD_F_PUSH:     heads_reg[n_reg[IW-1:0]] <= x_reg;
                bba_pkg::CMD_F_NEXT:
                begin
                    if (hit_reg && (prev_reg == '0))
                    begin
                        heads_reg[n_reg[IW-1:0]] <= link_q;
                    end
                end
                default: oc_reg <= oc_reg;
            endcase
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bba_pkg::CMD_CAPTURE:
            begin
                n_reg <= req_order;
                x_reg <= LW'(req_block_index);
            end
            bba_pkg::CMD_INIT_START:  rem_reg <= rem0;
            bba_pkg::CMD_INIT_CHUNK:  rem_reg <= rem_reg - chunk_pw;
            bba_pkg::CMD_A_POP_RD:    p_reg   <= head_n;
            bba_pkg::CMD_A_SCAN_INIT: i_reg   <= n_reg + OW'(1);
            bba_pkg::CMD_A_SCAN_NEXT: i_reg   <= i_reg + OW'(1);
            bba_pkg::CMD_A_TAKE_RD:
            begin
                p_reg <= head_i;
                j_reg <= i_reg;
            end
            bba_pkg::CMD_A_SPLIT:     j_reg   <= j_reg - OW'(1);
            bba_pkg::CMD_F_START:
            begin
                cur_reg   <= head_n;
                prev_reg  <= '0;
                steps_reg <= '0;
            end
            bba_pkg::CMD_F_PROBE:
            begin
                hit_reg  <= hit_r || hit_l;
                base_reg <= hit_l ? cur_reg : x_reg;
            end
            bba_pkg::CMD_F_NEXT:
            begin
                if (hit_reg)
                begin
                    x_reg <= base_reg;
                    n_reg <= n_reg + OW'(1);
                end
                else
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= link_q;
                    steps_reg <= steps_reg + SW'(1);
                end
            end
            bba_pkg::CMD_LOAD_OUT:
            begin
                out_block_reg  <= cmd.res_p ? p_reg[BW-1:0] : '0;
                out_status_reg <= cmd.res_fail;
            end
            default: hit_reg <= hit_reg;
        endcase
    end

    assign rsp_block_index_out = out_block_reg;
    assign rsp_status          = out_status_reg;
endmodule

@@ tb/buddy_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// randomized self-checking bench for the buddy block allocator: a shadow copy
// of the free lists predicts every response word; requests come in bursts,
// the response side stalls at random and once holds off for a long stretch
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;

    localparam int CLK_HALF   = 10;
    localparam int MAX_BLOCKS = bba_pkg::MAX_BLOCKS;
    localparam int MAX_ORDERS = bba_pkg::MAX_ORDERS;
    localparam int BLK_W      = bba_pkg::BLK_W;
    localparam int ORD_W      = bba_pkg::ORD_W;
    localparam int CNT_W      = bba_pkg::CNT_W;
    localparam int WALK_LIMIT = 2 * MAX_BLOCKS;

    typedef struct {
        logic [BLK_W-1:0] blk;
        logic             status;
    } rsp_word_t;

    typedef struct {
        logic [BLK_W-1:0] blk;
        logic [ORD_W-1:0] ord;
    } chunk_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // shadow allocator state
    int unsigned pool_size_reg = 1024;
    int unsigned pool_total    = 0;
    int unsigned n_orders      = 0;
    int unsigned heads [MAX_ORDERS];
    int unsigned links [MAX_BLOCKS];

    rsp_word_t pending_results [$];
    chunk_t    live_chunks [$];
    int        errors = 0;
    int        burst_left = 0;
    bit        sender_gaps = 1'b1;
    int        hold_cycles = 0;
    bit        stall_on = 1'b0;

    function automatic int unsigned link_rd(int unsigned b);
        return (b < MAX_BLOCKS) ? links[b] : 0;
    endfunction

    function automatic void link_wr(int unsigned b, int unsigned v);
        if (b < MAX_BLOCKS)
        begin
            links[b] = v;
        end
    endfunction

    // merged chunk must line up with the end of the pool
    function automatic bit aligned_to_end(int unsigned b, int unsigned k);
        int unsigned len;
        int unsigned num;
        len = 1 << k;
        num = ((pool_total - 1) % len) + 1;
        return (b % len) == (num % len);
    endfunction

    // rebuild the lists from the pool size, largest chunks at the top
    function automatic bit build_lists();
        int unsigned rem;
        int unsigned cnt;
        int unsigned k;
        int unsigned start;
        if (pool_size_reg < 2 || pool_size_reg > MAX_BLOCKS)
        begin
            return 1'b0;
        end
        rem = pool_size_reg - 1;
        cnt = 0;
        while ((rem >> cnt) > 1)
        begin
            cnt++;
        end
        cnt++;
        if (cnt > MAX_ORDERS)
        begin
            return 1'b0;
        end
        pool_total = pool_size_reg;
        n_orders = cnt;
        for (int i = 0; i < MAX_ORDERS; i++)
        begin
            heads[i] = 0;
        end
        while (rem > 0)
        begin
            k = 0;
            while ((rem >> k) > 1)
            begin
                k++;
            end
            start = 1 + rem - (1 << k);
            heads[k] = start;
            link_wr(start, 0);
            rem -= 1 << k;
        end
        return 1'b1;
    endfunction

    // pop or split; zero means no chunk
    function automatic int unsigned take_chunk(int unsigned n);
        int unsigned p;
        int unsigned i;
        int unsigned q;
        if (n >= n_orders)
        begin
            return 0;
        end
        p = heads[n];
        if (p != 0)
        begin
            heads[n] = link_rd(p);
            link_wr(p, 0);
            return p;
        end
        for (i = n + 1; i < n_orders; i++)
        begin
            if (heads[i] != 0)
            begin
                break;
            end
        end
        if (i >= n_orders)
        begin
            return 0;
        end
        p = heads[i];
        heads[i] = link_rd(p);
        for (int unsigned j = i; j > n; j--)
        begin
            q = p + (1 << (j - 1));
            heads[j - 1] = q;
            link_wr(q, 0);
        end
        link_wr(p, 0);
        return p;
    endfunction

    // walk the list for a buddy, merge upward while one is found
    function automatic void give_back(int unsigned x, int unsigned n);
        int unsigned prev;
        int unsigned cur;
        int unsigned len;
        int unsigned steps;
        int unsigned base;
        bit          merged;
        bit          hit;
        forever
        begin
            if (n >= n_orders)
            begin
                return;
            end
            prev = 0;
            steps = 0;
            merged = 1'b0;
            len = 1 << n;
            cur = heads[n];
            while (cur != 0 && steps < WALK_LIMIT)
            begin
                hit = 1'b0;
                base = x;
                if (cur == x + len)
                begin
                    hit = aligned_to_end(x, n + 1);
                end
                else if (x == cur + len)
                begin
                    hit = aligned_to_end(cur, n + 1);
                    base = cur;
                end
                if (hit)
                begin
                    if (prev == 0)
                    begin
                        heads[n] = link_rd(cur);
                    end
                    else
                    begin
                        link_wr(prev, link_rd(cur));
                    end
                    x = base;
                    n++;
                    merged = 1'b1;
                    break;
                end
                prev = cur;
                cur = link_rd(cur);
                steps++;
            end
            if (!merged)
            begin
                link_wr(x, heads[n]);
                heads[n] = x;
                return;
            end
        end
    endfunction

    function automatic rsp_word_t predict_word(bba_pkg::op_code_t op, logic [ORD_W-1:0] ord,
                                               logic [BLK_W-1:0] idx);
        rsp_word_t   r;
        int unsigned got;
        r.blk = '0;
        r.status = 1'b1;
        case (op)
            bba_pkg::OP_ALLOC:
            begin
                got = take_chunk(ord);
                r.blk = BLK_W'(got);
                r.status = (got == 0);
            end
            bba_pkg::OP_FREE:
            begin
                if (ord < n_orders && idx != 0 && idx < pool_total)
                begin
                    give_back(idx, ord);
                    r.status = 1'b0;
                end
            end
            bba_pkg::OP_INIT:
            begin
                r.status = !build_lists();
            end
            default: ;
        endcase
        return r;
    endfunction

    // request side: one word, gaps between bursts
    task automatic send_word(bba_pkg::op_code_t op, logic [ORD_W-1:0] ord,
                             logic [BLK_W-1:0] idx);
        logic      rdy;
        rsp_word_t r;
        chunk_t    c;
        if (burst_left <= 0)
        begin
            if (sender_gaps)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        req.valid       <= 1'b1;
        req.op          <= op;
        req.order       <= ord;
        req.block_index <= idx;
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end
        while (!rdy);
        burst_left--;
        r = predict_word(op, ord, idx);
        pending_results.push_back(r);
        if (op == bba_pkg::OP_ALLOC && r.status == 1'b0)
        begin
            c.blk = r.blk;
            c.ord = ord;
            live_chunks.push_back(c);
        end
        if (op == bba_pkg::OP_INIT && r.status == 1'b0)
        begin
            live_chunks.delete();
        end
    endtask

    // drain all responses, then let the sequencer settle
    task automatic wait_idle();
        req.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_pool_size(int unsigned v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        pool_size_reg = v & 11'h7FF;
    endtask

    // mostly small orders, now and then the whole field
    function automatic logic [ORD_W-1:0] pick_order();
        int unsigned top;
        top = (n_orders > 0) ? n_orders - 1 : 0;
        if ($urandom_range(0, 19) == 0)
        begin
            return ORD_W'($urandom_range(0, 15));
        end
        return ORD_W'($urandom_range(0, (top < 3) ? top : $urandom_range(3, top)));
    endfunction

    task automatic free_live_chunk();
        int     k;
        chunk_t c;
        k = $urandom_range(0, live_chunks.size() - 1);
        c = live_chunks[k];
        live_chunks.delete(k);
        send_word(bba_pkg::OP_FREE, c.ord, c.blk);
    endtask

    task automatic test_before_init();
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd5);
        send_word(bba_pkg::OP_NONE, 4'd0, '0);
    endtask

    // pool sizes out of range must leave the lists alone
    task automatic test_bad_pool_sizes();
        write_pool_size(0);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        write_pool_size(1);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        write_pool_size(1025);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        write_pool_size(2047);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
    endtask

    task automatic test_tiny_pools();
        // one usable block
        write_pool_size(2);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd1);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd0);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd2);
        send_word(bba_pkg::OP_ALLOC, 4'd1, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd15, '0);
        // split then merge back up to the top order
        write_pool_size(5);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd1);
        send_word(bba_pkg::OP_ALLOC, 4'd2, '0);
    endtask

    task automatic test_full_pool();
        write_pool_size(1024);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd9, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd0, '0);
        send_word(bba_pkg::OP_ALLOC, 4'd10, '0);
        send_word(bba_pkg::OP_NONE, 4'd15, 10'h3FF);
        send_word(bba_pkg::OP_FREE, 4'd0, 10'd1023);
    endtask

    task automatic test_random_phase(int unsigned pool, int count);
        int unsigned r;
        write_pool_size(pool);
        stall_on = $urandom_range(0, 1);
        sender_gaps = ($urandom_range(0, 3) != 0);
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 48 || (r < 88 && live_chunks.size() == 0))
            begin
                send_word(bba_pkg::OP_ALLOC, pick_order(), BLK_W'($urandom));
            end
            else if (r < 88)
            begin
                free_live_chunk();
            end
            else if (r < 93)
            begin
                // stray free: any index, any order
                send_word(bba_pkg::OP_FREE, ORD_W'($urandom_range(0, 15)),
                          BLK_W'($urandom));
            end
            else if (r < 97)
            begin
                send_word(bba_pkg::OP_NONE, ORD_W'($urandom), BLK_W'($urandom));
            end
            else
            begin
                send_word(bba_pkg::OP_INIT, ORD_W'($urandom), BLK_W'($urandom));
            end
        end
    endtask

    // response side held off long enough that the block backs up
    task automatic test_back_pressure();
        write_pool_size(256);
        sender_gaps = 1'b0;
        send_word(bba_pkg::OP_INIT, 4'd0, '0);
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
        begin
            if (live_chunks.size() != 0 && $urandom_range(0, 1))
            begin
                free_live_chunk();
            end
            else
            begin
                send_word(bba_pkg::OP_ALLOC, pick_order(), '0);
            end
        end
        sender_gaps = 1'b1;
    endtask

    // ready pattern, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready   <= 1'b0;
        end
        else
        begin
            rsp.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // sample between edges, check at the edge where the word moves
    logic             rsp_fire;
    logic [BLK_W-1:0] rsp_blk;
    logic             rsp_status;

    always @(negedge clk)
    begin
        rsp_fire   <= rsp.valid && rsp.ready;
        rsp_blk    <= rsp.block_index_out;
        rsp_status <= rsp.status;
    end

    always @(posedge clk)
    begin
        rsp_word_t w;
        if (rst_n && rsp_fire === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response word blk=%0d status=%0d",
                         $time, rsp_blk, rsp_status);
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (rsp_blk !== w.blk)
                begin
                    $display("%0t: block_index_out expected %0d actual %0d",
                             $time, w.blk, rsp_blk);
                    errors++;
                end
                if (rsp_status !== w.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.status, rsp_status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        req.valid       = 1'b0;
        req.op          = bba_pkg::OP_NONE;
        req.order       = '0;
        req.block_index = '0;
        for (int i = 0; i < MAX_ORDERS; i++)
        begin
            heads[i] = 0;
        end
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            links[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_init();
        test_bad_pool_sizes();
        test_tiny_pools();
        test_full_pool();
        test_random_phase(1024, 300);
        test_random_phase(37, 150);
        test_back_pressure();
        test_random_phase(513, 200);
        test_random_phase(2, 60);
        test_random_phase(1023, 200);
        test_random_phase(100, 150);
        test_random_phase($urandom_range(2, 1024), 150);

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("buddy_block_allocator test passed");
        end
        else
        begin
            $display("buddy_block_allocator test failed");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #1_000_000_000;
        $display("buddy_block_allocator test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_ram.sv
hdl/bba_ctrl.sv
hdl/bba_dp.sv
hdl/buddy_block_allocator.sv
tb/buddy_block_allocator_tb.sv
